/* hdl/hgbs_pkg.sv */
// shared types and constants for the group-by sum engine
package hgbs_pkg;

  localparam int unsigned TableSlotsDef = 2048;
  localparam int unsigned KeyW = 32;
  localparam int unsigned SumW = 32;
  localparam int unsigned SlotFieldW = 11;
  localparam logic [KeyW-1:0] EmptyKey = 32'hFFFF_FFFF;
  localparam logic [31:0] MixMul1 = 32'h85eb_ca6b;
  localparam logic [31:0] MixMul2 = 32'hc2b2_ae35;

  typedef enum logic [1:0] {
    MODE_AGG   = 2'd0,
    MODE_LOOK  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_RESERVED = 3'd3,
    ST_FOUND    = 3'd4,
    ST_ABSENT   = 3'd5,
    ST_READ     = 3'd6,
    ST_CLEARED  = 3'd7
  } status_e;

  // classified command from front to back
  typedef struct packed {
    mode_e             mode;
    logic              reserved;
    logic [KeyW-1:0]   key;
    logic [SumW-1:0]   value;
    logic [31:0]       hash;
    logic [SlotFieldW-1:0] slot_index;
  } cmd_t;

endpackage

/* hdl/hgbs_ram.sv */
// generic single-port ram with registered read
module hgbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // registered read, returns the old word on a write to the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

/* hdl/hgbs_front.sv */
// front end: accepts words, hashes keys in a pipeline and flags reserved keys
module hgbs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      mode_i,
  input  logic [31:0]     key_i,
  input  logic [31:0]     value_i,
  input  logic [10:0]     slot_index_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output hgbs_pkg::cmd_t  cmd_o
);

  logic            s1_valid_q, s2_valid_q;
  hgbs_pkg::cmd_t  s1_q, s2_q, s2_d;
  logic [31:0]     s1_x_q;
  logic [31:0]     x1, x2, x3;
  logic            adv2, adv1;

  assign adv2 = !s2_valid_q || cmd_ready_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_ready_o = adv1;

  // first multiply then second multiply in the next stage
  assign x1 = key_i ^ (key_i >> 16);
  assign x2 = s1_x_q ^ (s1_x_q >> 13);
  assign x3 = x2 * hgbs_pkg::MixMul2;

  // second stage word with the finished hash
  always_comb begin
    s2_d      = s1_q;
    s2_d.hash = x3 ^ (x3 >> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_q.mode       <= hgbs_pkg::mode_e'(mode_i);
      s1_q.reserved   <= (key_i == hgbs_pkg::EmptyKey);
      s1_q.key        <= key_i;
      s1_q.value      <= value_i;
      s1_q.hash       <= '0;
      s1_q.slot_index <= slot_index_i;
      s1_x_q          <= x1 * hgbs_pkg::MixMul1;
    end
    if (adv2 && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign cmd_valid_o = s2_valid_q;
  assign cmd_o = s2_q;

endmodule

/* hdl/hgbs_fifo.sv */
// short command queue between front and back
module hgbs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  hgbs_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output hgbs_pkg::cmd_t rd_data_o
);

  hgbs_pkg::cmd_t ent_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 3'd4);
  assign rd_valid_o = (cnt_q != 3'd0);
  assign rd_data_o  = ent_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) ent_q[wp_q] <= wr_data_i;
  end

endmodule

/* hdl/hgbs_back.sv */
// back end: probes the table, updates sums, reads and clears slots
module hgbs_back #(
  parameter int unsigned TableSlots = hgbs_pkg::TableSlotsDef  // power of two
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  hgbs_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [2:0]     status_o,
  output logic [10:0]    slot_o,
  output logic [31:0]    entry_key_o,
  output logic [31:0]    entry_sum_o,
  output logic           occupied_o
);

  localparam int unsigned AW = $clog2(TableSlots);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_WAIT  = 6'b000100,
    S_CHECK = 6'b001000,
    S_CLEAR = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  hgbs_pkg::cmd_t  cmd_q;
  logic [AW-1:0]   addr_q, addr_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic            res_valid_q;
  logic [2:0]      st_q, st_d;
  logic [AW-1:0]   rslot_q, rslot_d;
  logic [31:0]     rkey_q, rkey_d, rsum_q, rsum_d;
  logic            rocc_q, rocc_d;
  logic            we;
  logic [31:0]     wkey, wsum, rdkey, rdsum, sum_new;
  logic            load_res;
  logic            cmd_q_seen_q;

  // table memories
  hgbs_ram #(.Width(32), .Depth(TableSlots)) u_keys (
    .clk_i(clk_i), .we_i(we), .addr_i(addr_q), .wdata_i(wkey), .rdata_o(rdkey));
  hgbs_ram #(.Width(32), .Depth(TableSlots)) u_sums (
    .clk_i(clk_i), .we_i(we), .addr_i(addr_q), .wdata_i(wsum), .rdata_o(rdsum));

  assign cmd_ready_o = (state_q == S_IDLE);
  assign sum_new = rdsum + cmd_q.value;

  // probe and clear sequencer
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    rslot_d = rslot_q;
    rkey_d  = rkey_q;
    rsum_d  = rsum_q;
    rocc_d  = rocc_q;
    we      = 1'b0;
    wkey    = cmd_q.key;
    wsum    = sum_new;
    load_res = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cnt_d = '0;
          if (cmd_i.mode == hgbs_pkg::MODE_CLEAR) begin
            addr_d  = '0;
            state_d = S_CLEAR;
          end else if (cmd_i.mode == hgbs_pkg::MODE_READ) begin
            addr_d  = AW'(cmd_i.slot_index);
            state_d = S_WAIT;
          end else if (cmd_i.reserved) begin
            st_d = hgbs_pkg::ST_RESERVED;
            rslot_d = '0; rkey_d = '0; rsum_d = '0; rocc_d = 1'b0;
            state_d = S_OUT;
          end else begin
            addr_d  = cmd_i.hash[AW-1:0];
            state_d = S_WAIT;
          end
        end
      end
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: state_d = S_CHECK;
      S_CHECK: begin
        if (cmd_q.mode == hgbs_pkg::MODE_READ) begin
          st_d = hgbs_pkg::ST_READ;
          rslot_d = addr_q;
          rocc_d  = (rdkey != hgbs_pkg::EmptyKey);
          rkey_d  = rocc_d ? rdkey : '0;
          rsum_d  = rdsum;
          state_d = S_OUT;
        end else if (rdkey == cmd_q.key) begin
          rslot_d = addr_q; rkey_d = cmd_q.key; rocc_d = 1'b1;
          if (cmd_q.mode == hgbs_pkg::MODE_AGG) begin
            we = 1'b1; wkey = rdkey;
            st_d = hgbs_pkg::ST_UPDATED; rsum_d = sum_new;
          end else begin
            st_d = hgbs_pkg::ST_FOUND; rsum_d = rdsum;
          end
          state_d = S_OUT;
        end else if (rdkey == hgbs_pkg::EmptyKey) begin
          if (cmd_q.mode == hgbs_pkg::MODE_AGG) begin
            we = 1'b1;
            st_d = hgbs_pkg::ST_INSERTED;
            rslot_d = addr_q; rkey_d = cmd_q.key; rsum_d = sum_new; rocc_d = 1'b1;
          end else begin
            st_d = hgbs_pkg::ST_ABSENT;
            rslot_d = '0; rkey_d = '0; rsum_d = '0; rocc_d = 1'b0;
          end
          state_d = S_OUT;
        end else if (cnt_q == (AW+1)'(TableSlots - 1)) begin
          st_d = (cmd_q.mode == hgbs_pkg::MODE_AGG) ? hgbs_pkg::ST_FULL
                                                    : hgbs_pkg::ST_ABSENT;
          rslot_d = '0; rkey_d = '0; rsum_d = '0; rocc_d = 1'b0;
          state_d = S_OUT;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          addr_d  = addr_q + 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_CLEAR: begin
        we = 1'b1; wkey = hgbs_pkg::EmptyKey; wsum = '0;
        addr_d = addr_q + 1'b1;
        if (addr_q == AW'(TableSlots - 1)) begin
          st_d = hgbs_pkg::ST_CLEARED;
          rslot_d = '0; rkey_d = '0; rsum_d = '0; rocc_d = 1'b0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_valid_q || res_ready_i) begin
          load_res = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      state_q <= (state_q == S_CLEAR && st_d == hgbs_pkg::ST_CLEARED &&
                  !cmd_q_seen_q) ? S_IDLE : state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
      if (load_res) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // marks that the clear pass was commanded, not the one after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q_seen_q <= 1'b0;
    end else if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q_seen_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    rslot_q <= rslot_d;
    rkey_q  <= rkey_d;
    rsum_q  <= rsum_d;
    rocc_q  <= rocc_d;
    if (load_res) begin
      status_o    <= st_q;
      slot_o      <= 11'(rslot_q);
      entry_key_o <= rkey_q;
      entry_sum_o <= rsum_q;
      occupied_o  <= rocc_q;
    end
  end

  assign res_valid_o = res_valid_q;

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> (state_q == S_IDLE)) else $error("accept while busy");
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(TableSlots - 1)) else $error("probe count overrun");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i && !load_res) |=> $stable(entry_sum_o))
    else $error("result changed while stalled");
`endif

endmodule

/* hdl/hash_group_by_sum.sv */
// top level of the hash group-by sum engine
//
// channel   dir  tdata fields (low to high)                    tuser
// s_axis    in   mode[1:0] key[33:2] value[65:34] slot_index[76:66] -
// m_axis    out  status[2:0] slot[13:3] entry_key[45:14] entry_sum[77:46] occupied[78] -
//
// front end: two pipelined multiply stages for the hash, then the command queue
// back end: lookup or aggregate probes slot after slot from the hashed slot, a slot read
// visits the one slot, a reserved key skips the table (one-port table memory: address,
// read, then compare and write); clear walks every slot; after reset the same pass runs
// before the back end takes its first command
// a stalled result holds in the output register; the front fills a four-entry queue
module hash_group_by_sum #(
  parameter int unsigned TableSlots = hgbs_pkg::TableSlotsDef  // power of two
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // mode, key, value, slot_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // status, slot, entry_key, entry_sum, occupied
);

  logic           f_valid, f_ready, b_valid, b_ready;
  hgbs_pkg::cmd_t f_cmd, b_cmd;
  logic [2:0]     status;
  logic [10:0]    slot;
  logic [31:0]    ekey, esum;
  logic           occ;

  hgbs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tdata[1:0]), .key_i(s_axis_tdata[33:2]),
    .value_i(s_axis_tdata[65:34]), .slot_index_i(s_axis_tdata[76:66]),
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd));

  hgbs_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_cmd));

  hgbs_back #(.TableSlots(TableSlots)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .status_o(status), .slot_o(slot), .entry_key_o(ekey),
    .entry_sum_o(esum), .occupied_o(occ));

  assign m_axis_tdata = {1'b0, occ, esum, ekey, slot, status};

endmodule
